// File: rtl/fsba_pkg.sv
// Shared types and constants for the frame stack bitmap allocator.
// It has no dependencies. The top level and the testbench use it by scoped names.
package fsba_pkg;

	localparam int unsigned NUM_FRAMES_DEF  = 1024;
	localparam int unsigned FRAME_SHIFT_DEF = 21;

	localparam int unsigned ADDR_W   = 48;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned LIMIT_W  = 11;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_UNALIGNED = 3'd2,
		ST_NOT_ALLOC = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

endpackage

// File: rtl/frame_stack_bitmap_allocator_core.sv
// Top level of the frame stack bitmap allocator: request sequencer, output register and memories.
// It depends on fsba_pkg, fsba_ram and fsba_sweep.
//
// Usage: requests enter on the s_ stream. s_tuser carries the opcode (allocate or free).
// s_tdata carries the frame byte address, which is used by free only. Each request yields
// exactly one result on the m_ stream. m_tdata carries the granted address, and m_tuser
// carries the status.
// The frame limit register is written through cfg_wr_en and cfg_wr_data. The user must write it
// only while the block is idle; the block itself does not enforce this. A request passes a read
// step and then an execute step. In the read step, the free stack or the bitmap is read. In the
// execute step, the result is formed and the memories are written back. The next request is
// taken only after the execute step, so the block cannot take a new request before it is
// through with the last. This is set by the registered read of the RAMs and by the stack
// pointer dependence. The output register holds a finished result while the receiver stalls,
// and one further request may be taken meanwhile. That request then waits in its second stage
// until the register is free. After reset, the block sweeps every bitmap address to mark every
// frame as allocated, and s_tready stays low during the sweep. The stack starts empty. The free
// list is loaded by issuing free requests.
module frame_stack_bitmap_allocator_core #(
	parameter int unsigned NUM_FRAMES  = fsba_pkg::NUM_FRAMES_DEF,
	parameter int unsigned FRAME_SHIFT = fsba_pkg::FRAME_SHIFT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fsba_pkg::LIMIT_W-1:0]  cfg_wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fsba_pkg::ADDR_W-1:0]   s_tdata,  // [47:0] byte_addr
	input  logic [0:0]                    s_tuser,  // [0] opcode
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fsba_pkg::ADDR_W-1:0]   m_tdata,  // [47:0] granted_address
	output logic [fsba_pkg::STATUS_W-1:0] m_tuser   // [2:0] status
);

	localparam int unsigned ADDR_W = fsba_pkg::ADDR_W;
	localparam int unsigned IDX_W  = $clog2(NUM_FRAMES);
	localparam int unsigned CNT_W  = IDX_W + 1;
	localparam int unsigned FIDX_W = ADDR_W - FRAME_SHIFT;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	state_t                       state_q;
	logic [CNT_W-1:0]             count_q;
	logic [fsba_pkg::LIMIT_W-1:0] limit_q;

	fsba_pkg::opcode_t op_s1;
	fsba_pkg::status_t pre_st_s1;
	logic [IDX_W-1:0]  idx_s1;

	logic                          m_tvalid_q;
	logic [ADDR_W-1:0]             m_tdata_q;
	logic [fsba_pkg::STATUS_W-1:0] m_tuser_q;

	logic             sweep_active;
	logic [IDX_W-1:0] sweep_addr;

	logic              accept;
	fsba_pkg::opcode_t in_op;
	logic [FIDX_W-1:0] in_fidx;
	logic              align_err;
	logic              range_err;
	fsba_pkg::status_t in_pre_st;
	logic [CNT_W-1:0]  count_dec;

	logic             stk_rd_en;
	logic [IDX_W-1:0] stk_rd_addr;
	logic [IDX_W-1:0] stk_rd_data;
	logic             stk_wr_en;

	logic             bm_rd_en;
	logic [0:0]       bm_rd_data;
	logic             bm_wr_en;
	logic [IDX_W-1:0] bm_wr_addr;
	logic [0:0]       bm_wr_data;

	logic              fire;
	logic              alloc_ok;
	logic              free_ok;
	fsba_pkg::status_t ex_st;
	logic [ADDR_W-1:0] ex_addr;

	fsba_sweep #(
		.NUM_FRAMES(NUM_FRAMES)
	) u_sweep (
		.clk   (clk),
		.arst_n(arst_n),
		.active(sweep_active),
		.addr  (sweep_addr)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign in_op     = fsba_pkg::opcode_t'(s_tuser[0]);
	assign in_fidx   = s_tdata[ADDR_W-1:FRAME_SHIFT];
	assign align_err = |s_tdata[FRAME_SHIFT-1:0];
	assign range_err = (in_fidx >= FIDX_W'(limit_q)) || (in_fidx >= FIDX_W'(NUM_FRAMES));
	assign count_dec = count_q - CNT_W'(1);

	always_comb begin
		if (in_op == fsba_pkg::OP_ALLOC) begin
			in_pre_st = (count_q == '0) ? fsba_pkg::ST_EMPTY : fsba_pkg::ST_OK;
		end else if (align_err) begin
			in_pre_st = fsba_pkg::ST_UNALIGNED;
		end else if (range_err) begin
			in_pre_st = fsba_pkg::ST_RANGE;
		end else begin
			in_pre_st = fsba_pkg::ST_OK;
		end
	end

	assign stk_rd_en   = accept && (in_op == fsba_pkg::OP_ALLOC);
	assign stk_rd_addr = count_dec[IDX_W-1:0];
	assign bm_rd_en    = accept && (in_op == fsba_pkg::OP_FREE);

	assign fire     = (state_q == S_EXEC) && (!m_tvalid_q || m_tready);
	assign alloc_ok = (op_s1 == fsba_pkg::OP_ALLOC) && (pre_st_s1 == fsba_pkg::ST_OK);
	assign free_ok  = (op_s1 == fsba_pkg::OP_FREE) && (pre_st_s1 == fsba_pkg::ST_OK) &&
		bm_rd_data[0] && (count_q < CNT_W'(NUM_FRAMES));

	always_comb begin
		ex_addr = '0;
		if (alloc_ok) begin
			ex_st   = fsba_pkg::ST_OK;
			ex_addr = ADDR_W'(stk_rd_data) << FRAME_SHIFT;
		end else if (free_ok) begin
			ex_st = fsba_pkg::ST_OK;
		end else if ((op_s1 == fsba_pkg::OP_FREE) && (pre_st_s1 == fsba_pkg::ST_OK)) begin
			ex_st = fsba_pkg::ST_NOT_ALLOC;
		end else begin
			ex_st = pre_st_s1;
		end
	end

	assign stk_wr_en = fire && free_ok;

	always_comb begin
		if (sweep_active) begin
			bm_wr_en   = 1'b1;
			bm_wr_addr = sweep_addr;
			bm_wr_data = 1'b1;
		end else begin
			bm_wr_en   = fire && (alloc_ok || free_ok);
			bm_wr_addr = alloc_ok ? stk_rd_data : idx_s1;
			bm_wr_data = alloc_ok;
		end
	end

	fsba_ram #(
		.WIDTH(IDX_W),
		.DEPTH(NUM_FRAMES)
	) u_stack_ram (
		.clk    (clk),
		.wr_en  (stk_wr_en),
		.wr_addr(count_q[IDX_W-1:0]),
		.wr_data(idx_s1),
		.rd_en  (stk_rd_en),
		.rd_addr(stk_rd_addr),
		.rd_data(stk_rd_data)
	);

	fsba_ram #(
		.WIDTH(1),
		.DEPTH(NUM_FRAMES)
	) u_bitmap_ram (
		.clk    (clk),
		.wr_en  (bm_wr_en),
		.wr_addr(bm_wr_addr),
		.wr_data(bm_wr_data),
		.rd_en  (bm_rd_en),
		.rd_addr(in_fidx[IDX_W-1:0]),
		.rd_data(bm_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= fsba_pkg::LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (!sweep_active) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (fire) begin
				m_tvalid_q <= 1'b1;
				if (alloc_ok) begin
					count_q <= count_q - CNT_W'(1);
				end else if (free_ok) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= in_op;
			pre_st_s1 <= in_pre_st;
			idx_s1    <= in_fidx[IDX_W-1:0];
		end
		if (fire) begin
			m_tdata_q <= ex_addr;
			m_tuser_q <= ex_st;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_no_request_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_active |-> !s_tready)
		else $error("Request taken while the bitmap sweep is running.");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(NUM_FRAMES))
		else $error("Stack count exceeds the number of frames.");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_EXEC))
		else $error("Accepted request did not reach the execute stage.");

	a_alloc_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && alloc_ok) |-> (count_q != '0))
		else $error("Allocation granted from an empty stack.");

	a_result_after_fire: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> m_tvalid_q)
		else $error("Completed request produced no result.");

endmodule

// File: rtl/fsba_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// It has no dependencies. The top level uses it for the free stack and the allocation bitmap.
module fsba_ram #(
	parameter int unsigned WIDTH = 10,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/fsba_sweep.sv
// Post-reset sweep that walks every bitmap address once, so that every frame is marked allocated.
// It has no dependencies. The top level instantiates it.
module fsba_sweep #(
	parameter int unsigned NUM_FRAMES = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          active,
	output logic [$clog2(NUM_FRAMES)-1:0] addr
);

	localparam int unsigned IDX_W = $clog2(NUM_FRAMES);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(NUM_FRAMES - 1);

	logic             active_q;
	logic [IDX_W-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b1;
			addr_q   <= '0;
		end else if (active_q) begin
			addr_q <= addr_q + IDX_W'(1);
			if (addr_q == LAST) begin
				active_q <= 1'b0;
			end
		end
	end

	assign active = active_q;
	assign addr   = addr_q;

endmodule

// File: test/tb_frame_stack_bitmap_allocator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_stack_bitmap_allocator_core: directed and random allocate
// and free requests with random idling on both streams, checked against a cycle-free mirror.
// It depends on fsba_pkg and the allocator RTL only.
module tb_frame_stack_bitmap_allocator_core;

	localparam int unsigned NUM_FRAMES   = fsba_pkg::NUM_FRAMES_DEF;
	localparam int unsigned FRAME_SHIFT  = fsba_pkg::FRAME_SHIFT_DEF;
	localparam int unsigned ADDR_W       = fsba_pkg::ADDR_W;
	localparam int unsigned LIMIT_W      = fsba_pkg::LIMIT_W;
	localparam int unsigned STATUS_W     = fsba_pkg::STATUS_W;
	localparam int unsigned IDX_W        = $clog2(NUM_FRAMES);
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned PHASE_ITEMS  = 305;

	typedef struct packed {
		logic [ADDR_W-1:0] granted;
		fsba_pkg::status_t status;
	} grant_result_t;

	class allocator_mirror;
		bit                  allocated [NUM_FRAMES];
		bit [IDX_W-1:0]      stack [NUM_FRAMES];
		int unsigned         depth;
		logic [LIMIT_W-1:0]  limit;
		grant_result_t       due [$];
		int                  errors;

		function new();
			foreach (allocated[i]) allocated[i] = 1'b1;
			depth  = 0;
			limit  = fsba_pkg::LIMIT_RESET;
			errors = 0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] v);
			limit = v;
		endfunction

		function int unsigned span();
			return (limit > NUM_FRAMES) ? NUM_FRAMES : int'(limit);
		endfunction

		function int outstanding();
			return due.size();
		endfunction

		function grant_result_t apply_request(fsba_pkg::opcode_t op, logic [ADDR_W-1:0] addr);
			grant_result_t                  r;
			logic [ADDR_W-FRAME_SHIFT-1:0]  idx_full;
			int unsigned                    idx;
			r.granted = '0;
			r.status  = fsba_pkg::ST_OK;
			idx_full  = addr[ADDR_W-1:FRAME_SHIFT];
			if (op == fsba_pkg::OP_ALLOC) begin
				if (depth == 0) begin
					r.status = fsba_pkg::ST_EMPTY;
				end else begin
					depth--;
					idx = stack[depth];
					allocated[idx] = 1'b1;
					r.granted = ADDR_W'(idx) << FRAME_SHIFT;
				end
			end else if (addr[FRAME_SHIFT-1:0] != '0) begin
				r.status = fsba_pkg::ST_UNALIGNED;
			end else if (idx_full >= span()) begin
				r.status = fsba_pkg::ST_RANGE;
			end else if (!allocated[idx_full] || depth >= NUM_FRAMES) begin
				r.status = fsba_pkg::ST_NOT_ALLOC;
			end else begin
				allocated[idx_full] = 1'b0;
				stack[depth] = idx_full[IDX_W-1:0];
				depth++;
			end
			return r;
		endfunction

		function void note_request(fsba_pkg::opcode_t op, logic [ADDR_W-1:0] addr);
			due.push_back(apply_request(op, addr));
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("mismatch %0d at %0t: %s", errors, $time, msg);
		endtask

		task check_result(logic [ADDR_W-1:0] granted, logic [STATUS_W-1:0] status);
			grant_result_t want;
			if (due.size() == 0) begin
				report_mismatch($sformatf("result with no request outstanding: addr %h status %0d",
					granted, status));
			end else begin
				want = due.pop_front();
				if (granted !== want.granted) begin
					report_mismatch($sformatf("granted address %h, expected %h", granted,
						want.granted));
				end
				if (status !== want.status) begin
					report_mismatch($sformatf("status %0d, expected %s", status, want.status.name()));
				end
			end
		endtask
	endclass

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic [LIMIT_W-1:0]   cfg_wr_data = '0;
	logic                 s_tvalid    = 1'b0;
	logic                 s_tready;
	logic [ADDR_W-1:0]    s_tdata     = '0;
	logic [0:0]           s_tuser     = '0;
	logic                 m_tvalid;
	logic                 m_tready    = 1'b0;
	logic [ADDR_W-1:0]    m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	allocator_mirror ledger;
	allocator_mirror plan;
	int              hold_left  = 0;
	int              r_idle_pct = 72;
	int              s_idle_pct = 24;

	frame_stack_bitmap_allocator_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	always #1 clk = ~clk;

	// A long hold-off lets the block fill up and stall its input.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= r_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en) ledger.set_limit(cfg_wr_data);
			if (s_tvalid && s_tready) begin
				ledger.note_request(fsba_pkg::opcode_t'(s_tuser), s_tdata);
			end
			if (m_tvalid && m_tready) ledger.check_result(m_tdata, m_tuser);
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic logic [ADDR_W-1:0] frame_addr(int unsigned idx);
		return ADDR_W'(idx) << FRAME_SHIFT;
	endfunction

	task automatic issue(fsba_pkg::opcode_t op, logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= addr;
		do @(posedge clk); while (!s_tready);
		void'(plan.apply_request(op, addr));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.outstanding() != 0) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] v);
		cfg_wr_data <= v;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		plan.set_limit(v);
		@(posedge clk);
	endtask

	// Mostly allocations and well-formed frees of frames below the limit, the rest double frees,
	// out-of-range and unaligned addresses.
	task automatic random_request();
		int unsigned       pick;
		int unsigned       lim;
		logic [ADDR_W-1:0] a;
		lim  = plan.span();
		pick = $urandom_range(99);
		a    = {16'($urandom), $urandom};
		if (pick < 42) begin
			issue(fsba_pkg::OP_ALLOC, a);
		end else if (pick < 80 && lim > 0) begin
			issue(fsba_pkg::OP_FREE, frame_addr($urandom_range(lim - 1)));
		end else if (pick < 86 && plan.depth > 0) begin
			issue(fsba_pkg::OP_FREE, frame_addr(plan.stack[plan.depth - 1]));
		end else if (pick < 93) begin
			if ($urandom_range(3) == 0) begin
				issue(fsba_pkg::OP_FREE, frame_addr(lim));
			end else begin
				issue(fsba_pkg::OP_FREE, {27'($urandom_range(32'h7FF_FFFF, lim)), 21'd0});
			end
		end else begin
			if (a[FRAME_SHIFT-1:0] == '0) a[0] = 1'b1;
			issue(fsba_pkg::OP_FREE, a);
		end
	endtask

	initial begin
		int                 ph;
		int                 k;
		logic [LIMIT_W-1:0] lim;
		ledger = new();
		plan   = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_limit(fsba_pkg::LIMIT_RESET);

		issue(fsba_pkg::OP_ALLOC, '0);
		issue(fsba_pkg::OP_FREE, frame_addr(0));
		issue(fsba_pkg::OP_FREE, frame_addr(0));
		issue(fsba_pkg::OP_FREE, 48'd1);
		issue(fsba_pkg::OP_FREE, 48'h1 << (FRAME_SHIFT - 1));
		issue(fsba_pkg::OP_FREE, '1);
		issue(fsba_pkg::OP_FREE, frame_addr(NUM_FRAMES - 1));
		issue(fsba_pkg::OP_FREE, frame_addr(NUM_FRAMES));
		issue(fsba_pkg::OP_FREE, {27'h7FF_FFFF, 21'd0});
		issue(fsba_pkg::OP_ALLOC, '1);
		issue(fsba_pkg::OP_ALLOC, 48'h5555_5555_5555);
		issue(fsba_pkg::OP_ALLOC, '0);
		issue(fsba_pkg::OP_FREE, frame_addr(5));
		drain();
		write_limit(11'd3);
		issue(fsba_pkg::OP_FREE, frame_addr(5));
		issue(fsba_pkg::OP_FREE, frame_addr(2));
		issue(fsba_pkg::OP_FREE, frame_addr(3));
		issue(fsba_pkg::OP_ALLOC, '0);
		issue(fsba_pkg::OP_ALLOC, '0);
		drain();
		write_limit(11'd0);
		issue(fsba_pkg::OP_FREE, frame_addr(0));
		drain();
		write_limit(11'h7FF);
		issue(fsba_pkg::OP_FREE, frame_addr(NUM_FRAMES - 1));
		issue(fsba_pkg::OP_FREE, frame_addr(NUM_FRAMES));
		issue(fsba_pkg::OP_ALLOC, '0);

		for (ph = 0; ph < 6; ph++) begin
			drain();
			if (ph == 2) begin
				r_idle_pct <= 24;
				s_idle_pct = 72;
			end else if (ph == 4) begin
				r_idle_pct <= 0;
				s_idle_pct = 0;
			end
			case (ph)
				0: lim = fsba_pkg::LIMIT_RESET;
				1: lim = 11'd1;
				2: lim = 11'h7FF;
				3: lim = LIMIT_W'($urandom_range(NUM_FRAMES - 1, 2));
				4: lim = 11'd64;
				default: lim = fsba_pkg::LIMIT_RESET;
			endcase
			write_limit(lim);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if ((ph == 0 || ph == 4) && k == 100) hold_left <= 300;
				random_request();
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (ledger.errors == 0 && ledger.outstanding() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/fsba_pkg.sv
rtl/fsba_ram.sv
rtl/fsba_sweep.sv
rtl/frame_stack_bitmap_allocator_core.sv
test/tb_frame_stack_bitmap_allocator_core.sv
